// ----- rtl/core/kti_pkg.sv -----
// Package for the keyframe table interpolator: payload structs, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
package kti_pkg;
	localparam int MAX_KEYS_DEF = 64;

	localparam logic [1:0] FUNC_SET = 2'd0;
	localparam logic [1:0] FUNC_DEL = 2'd1;
	localparam logic [1:0] FUNC_QRY = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [15:0]        key_frame;
		logic signed [31:0] key_value;
	} kti_in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         status;
		logic [6:0]         entries_used;
	} kti_out_t;
endpackage

// ----- rtl/core/kti_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module kti_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [48:0] dividend,
	input  logic [16:0]        divisor,
	output logic               done,
	output logic signed [48:0] quotient
);
	logic [48:0] mag_q;
	logic [48:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] dvs_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [17:0] trial;
	logic [17:0] diff;

	// One restoring step per cycle.
	assign trial = {rem_q, mag_q[48]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd49;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[48];
			mag_q <= dividend[48] ? 49'(-dividend) : dividend;
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[47:0], 1'b0};
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				quo_q <= {quo_q[47:0], 1'b1};
			end else begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[47:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? 49'(-quo_q) : quo_q;
endmodule

// ----- rtl/core/kti_ctrl.sv -----
// Sequencer for the keyframe table: scans, shifts and interpolates over two memories.
// Depends on kti_pkg and kti_div.
`timescale 1ns / 1ps
module kti_ctrl #(
	parameter int MAX_KEYS = kti_pkg::MAX_KEYS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  kti_pkg::kti_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output kti_pkg::kti_out_t out_data
);
	import kti_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_SCANW = 4'd2;
	localparam logic [3:0] S_DEC   = 4'd3;
	localparam logic [3:0] S_SHRD  = 4'd4;
	localparam logic [3:0] S_SHWR  = 4'd5;
	localparam logic [3:0] S_PREV  = 4'd6;
	localparam logic [3:0] S_PREVW = 4'd7;
	localparam logic [3:0] S_DIVGO = 4'd8;
	localparam logic [3:0] S_DIVW  = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	// Table memories, one write and one registered read per cycle.
	logic [15:0]        frame_mem [MAX_KEYS];
	logic signed [31:0] value_mem [MAX_KEYS];
	logic [15:0]        rd_frame;
	logic signed [31:0] rd_value;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic               wr_en;
	logic [15:0]        wr_frame;
	logic signed [31:0] wr_value;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= wr_frame;
			value_mem[wr_addr] <= wr_value;
		end
		rd_frame <= frame_mem[rd_addr];
		rd_value <= value_mem[rd_addr];
	end

	logic [3:0]         state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      ptr_q;
	kti_in_t            op_q;
	logic [15:0]        bframe_q;
	logic signed [31:0] bvalue_q;
	logic               hit_q;
	kti_out_t           res_q;
	logic               vld_q;
	logic               div_start;
	logic               div_done;
	logic signed [48:0] div_q;
	logic signed [48:0] dividend_q;
	logic [16:0]        divisor_q;
	logic signed [31:0] avalue_q;

	kti_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dividend_q),
		.divisor(divisor_q), .done(div_done), .quotient(div_q)
	);

	assign in_ready  = (state_q == S_IDLE) && !vld_q;
	assign out_valid = vld_q;
	assign out_data  = res_q;
	assign div_start = (state_q == S_DIVGO);

	// Read address: scan index, shift source, or the entry before the hit.
	// An insert moves the entry below the pointer up; a delete moves the pointer entry down.
	always_comb begin
		rd_addr = idx_q[AW-1:0];
		if (state_q == S_SHRD) begin
			if (op_q.func == FUNC_SET) rd_addr = AW'(ptr_q - CW'(1));
			else rd_addr = ptr_q[AW-1:0];
		end
		if (state_q == S_PREV) rd_addr = AW'(idx_q - CW'(1));
	end

	// Memory writes during shift, overwrite and insert.
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = ptr_q[AW-1:0];
		wr_frame = rd_frame;
		wr_value = rd_value;
		if (state_q == S_SHWR) begin
			wr_en = 1'b1;
			if (op_q.func == FUNC_SET) begin
				wr_addr = ptr_q[AW-1:0];
			end else begin
				wr_addr = AW'(ptr_q - CW'(1));
			end
		end else if (state_q == S_DEC && op_q.func == FUNC_SET && hit_q) begin
			wr_en    = 1'b1;
			wr_addr  = idx_q[AW-1:0];
			wr_frame = op_q.key_frame;
			wr_value = op_q.key_value;
		end else if (state_q == S_DEC && op_q.func == FUNC_SET
				&& count_q < CW'(MAX_KEYS) && ptr_q == idx_q) begin
			wr_en    = 1'b1;
			wr_addr  = idx_q[AW-1:0];
			wr_frame = op_q.key_frame;
			wr_value = op_q.key_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (vld_q && out_ready) vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= S_SCAN;
					end
				end
				// Issue a read of the scan entry, or stop at the end.
				S_SCAN: begin
					if (idx_q >= count_q) begin
						state_q <= S_DEC;
					end else begin
						state_q <= S_SCANW;
					end
				end
				S_SCANW: begin
					if (rd_frame >= op_q.key_frame) begin
						state_q <= S_DEC;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_DEC: begin
					state_q <= S_DONE;
					case (op_q.func)
						FUNC_SET: begin
							if (!hit_q && count_q < CW'(MAX_KEYS)) begin
								if (ptr_q == idx_q) begin
									count_q <= count_q + CW'(1);
								end else begin
									state_q <= S_SHRD;
								end
							end
						end
						FUNC_DEL: begin
							if (hit_q) begin
								if (ptr_q >= count_q) begin
									count_q <= count_q - CW'(1);
								end else begin
									state_q <= S_SHRD;
								end
							end
						end
						FUNC_QRY: begin
							if (count_q != '0 && idx_q != '0 && idx_q < count_q) begin
								state_q <= S_PREV;
							end
						end
						default: ;
					endcase
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					state_q <= S_SHRD;
					if (op_q.func == FUNC_SET) begin
						if (ptr_q - CW'(1) == idx_q) begin
							state_q <= S_DEC;
						end
					end else if (ptr_q + CW'(1) >= count_q) begin
						state_q <= S_DEC;
					end
				end
				S_PREV:  state_q <= S_PREVW;
				S_PREVW: state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
					vld_q   <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers that follow the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q  <= in_data;
				idx_q <= '0;
				hit_q <= 1'b0;
				if (in_valid && in_ready) res_q <= '0;
			end
			S_SCANW: begin
				// The last entry read is kept; past the end it is the last keyframe.
				bframe_q <= rd_frame;
				bvalue_q <= rd_value;
				if (rd_frame >= op_q.key_frame) begin
					hit_q <= (rd_frame == op_q.key_frame);
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_SCAN: begin
				// Insert shifts from the top down; delete shifts from the hit up.
				if (op_q.func == FUNC_SET) ptr_q <= count_q;
				else ptr_q <= idx_q + CW'(1);
				if (idx_q >= count_q) hit_q <= 1'b0;
			end
			S_SHRD: begin
				if (op_q.func == FUNC_SET) ptr_q <= ptr_q;
			end
			S_SHWR: begin
				if (op_q.func == FUNC_SET) ptr_q <= ptr_q - CW'(1);
				else ptr_q <= ptr_q + CW'(1);
			end
			S_DEC: begin
				res_q.status <= ST_OK;
				case (op_q.func)
					FUNC_SET: begin
						if (!hit_q && count_q >= CW'(MAX_KEYS)) res_q.status <= ST_FULL;
					end
					FUNC_DEL: begin
						if (!hit_q) res_q.status <= ST_ABSENT;
					end
					FUNC_QRY: begin
						if (count_q == '0) res_q.status <= ST_ABSENT;
						else if (idx_q == '0) res_q.result_value <= bvalue_q;
						else if (idx_q >= count_q) res_q.result_value <= bvalue_q;
					end
					default: ;
				endcase
			end
			S_PREVW: begin
				avalue_q   <= rd_value;
				dividend_q <= 49'((33'(bvalue_q) - 33'(rd_value)) *
					$signed({1'b0, op_q.key_frame - rd_frame}));
				divisor_q  <= {1'b0, bframe_q - rd_frame};
			end
			S_DIVW: begin
				if (div_done) res_q.result_value <= 32'(avalue_q + div_q[31:0]);
			end
			S_DONE: begin
				res_q.entries_used <= 7'(count_q);
			end
			default: ;
		endcase
	end
endmodule

// ----- rtl/core/keyframe_table_interpolator_unit.sv -----
// Keyframe table interpolator top level: sorted table with linear interpolation.
// One operation at a time: a scan, then a shift for some inserts and deletes, or a divide for a query.
// A scan reads one entry at a time from the table memory, and the divider is iterative.
// A new word is taken only after the previous result word has been accepted.
// Reset (arst_n low) empties the table at once; no clearing pass is needed.
// Depends on kti_pkg and kti_ctrl.
`timescale 1ns / 1ps
module keyframe_table_interpolator_unit #(
	parameter int MAX_KEYS = kti_pkg::MAX_KEYS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kti_pkg::kti_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output kti_pkg::kti_out_t out_data
);
	import kti_pkg::*;

	kti_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

// ----- rtl/core/kti_checker.sv -----
// Port-level checks for the keyframe table interpolator, bound to the top level.
// Depends on kti_pkg.
`timescale 1ns / 1ps
module kti_port_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input kti_pkg::kti_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input kti_pkg::kti_out_t out_data
);
	import kti_pkg::*;

	// A held result word stays stable.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// No new word is taken while a result waits.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	// Status never shows the unused code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status");

	// A result with full status carries zero value.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |-> out_data.result_value == '0)
		else $error("full status with nonzero value");
endmodule

bind keyframe_table_interpolator_unit kti_port_checker u_kti_checker (.*);
